[hdl/retf_pkg.sv]
// Shared types and constants for the ray edge triple finder.
// Used by retf_front, retf_evq, retf_back and ray_edge_triple_finder; no dependencies.
package retf_pkg;

	localparam int PIX_W       = 8;
	localparam int MEAN_W      = 16;
	localparam int POS_W       = 10;
	localparam int STRENGTH_W  = 16;
	localparam int SCORE_W     = 18;
	localparam int RATE_W      = 9;
	localparam int THRESH_W    = 16;
	localparam int PENALTY_W   = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int POS_LIMIT              = (1 << POS_W) - 1;
	localparam int MAX_RAY_LENGTH_DEFAULT = 1024;
	localparam int EVQ_DEPTH_DEFAULT      = 4;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MEAN_RATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_PENALTY    = 2'd2;

	localparam logic [RATE_W-1:0]    MEAN_RATE_RESET      = 9'd26;
	localparam logic [THRESH_W-1:0]  EDGE_THRESHOLD_RESET = 16'd5120;
	localparam logic [PENALTY_W-1:0] GAP_PENALTY_RESET    = 16'd256;

	typedef struct packed {
		logic [RATE_W-1:0]    mean_rate;
		logic [THRESH_W-1:0]  edge_threshold;
		logic [PENALTY_W-1:0] gap_penalty;
	} cfg_t;

	// One entry of the event queue: a transition, the end of a ray, or both.
	typedef struct packed {
		logic                  edge_hit;
		logic                  last;
		logic [POS_W-1:0]      pos;
		logic [STRENGTH_W-1:0] strength;
	} evt_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   pos0;
		logic [POS_W-1:0]   pos1;
		logic [POS_W-1:0]   pos2;
		logic [SCORE_W-1:0] score;
	} res_t;

endpackage

[hdl/retf_front.sv]
// Front end: running mean, edge detection and position counting per pixel.
// Emits transition and end-of-ray events. Depends on retf_pkg.
module retf_front #(
	parameter int MAX_RAY_LENGTH = retf_pkg::MAX_RAY_LENGTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  retf_pkg::cfg_t              cfg,
	input  logic                        pix_valid,
	input  logic [retf_pkg::PIX_W-1:0]  pix,
	input  logic                        pix_last,
	input  logic                        evq_full,
	output logic                        pix_ready,
	output logic                        evt_push,
	output retf_pkg::evt_t              evt
);

	localparam int POS_MAX = (MAX_RAY_LENGTH - 1 < retf_pkg::POS_LIMIT) ?
		MAX_RAY_LENGTH - 1 : retf_pkg::POS_LIMIT;
	localparam logic [retf_pkg::POS_W-1:0] POS_MAX_V = retf_pkg::POS_W'(POS_MAX);

	logic [retf_pkg::MEAN_W-1:0] mean_q;
	logic                        started_q;
	logic                        inside_q;
	logic [retf_pkg::POS_W-1:0]  pcnt_q;

	logic                              accept;
	logic signed [17:0]                dv;
	logic signed [27:0]                prod;
	logic signed [19:0]                step_v;
	logic signed [19:0]                mean_sum;
	logic [retf_pkg::MEAN_W-1:0]       mean_next;
	logic [17:0]                       mag_w;
	logic [retf_pkg::STRENGTH_W-1:0]   mag;
	logic                              over;
	logic                              edge_hit;

	assign pix_ready = !evq_full;
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		dv       = $signed({2'b00, pix, 8'h00}) - $signed({2'b00, mean_q});
		prod     = $signed({1'b0, cfg.mean_rate}) * dv;
		// Arithmetic shift gives the floor of the scaled step.
		step_v   = prod[27:8];
		mean_sum = $signed({4'b0000, mean_q}) + step_v;
		if (mean_sum < 0) begin
			mean_next = '0;
		end else if (mean_sum > 20'sd65535) begin
			mean_next = '1;
		end else begin
			mean_next = mean_sum[retf_pkg::MEAN_W-1:0];
		end
		mag_w    = dv[17] ? 18'(-dv) : 18'(dv);
		mag      = mag_w[retf_pkg::STRENGTH_W-1:0];
		over     = mag >= cfg.edge_threshold;
		edge_hit = started_q && over && !inside_q;
	end

	assign evt_push      = accept && (edge_hit || pix_last);
	assign evt.edge_hit  = edge_hit;
	assign evt.last      = pix_last;
	assign evt.pos       = pcnt_q;
	assign evt.strength  = mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q    <= '0;
			started_q <= 1'b0;
			inside_q  <= 1'b0;
			pcnt_q    <= '0;
		end else if (accept) begin
			if (pix_last) begin
				mean_q    <= '0;
				started_q <= 1'b0;
				inside_q  <= 1'b0;
				pcnt_q    <= '0;
			end else begin
				pcnt_q <= (pcnt_q == POS_MAX_V) ? POS_MAX_V : pcnt_q + 1'b1;
				if (!started_q) begin
					started_q <= 1'b1;
					mean_q    <= {pix, 8'h00};
					inside_q  <= 1'b0;
				end else begin
					mean_q   <= mean_next;
					inside_q <= over;
				end
			end
		end
	end

endmodule

[hdl/retf_evq.sv]
// Short event queue between the front end and the scoring back end.
// Register ring with one push and one pop port. Depends on retf_pkg.
module retf_evq #(
	parameter int DEPTH = retf_pkg::EVQ_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  retf_pkg::evt_t push_data,
	input  logic           pop,
	output retf_pkg::evt_t head,
	output logic           full,
	output logic           empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	retf_pkg::evt_t    slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hdl/retf_back.sv]
// Back end: scores each window of three transitions, keeps the best one and
// drives the registered result at the end of a ray. Depends on retf_pkg.
module retf_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [retf_pkg::PENALTY_W-1:0]   gap_penalty,
	input  retf_pkg::evt_t                   head,
	input  logic                             empty,
	output logic                             pop,
	output logic                             res_valid,
	input  logic                             res_ready,
	output retf_pkg::res_t                   res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_PEN  = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam int SQ_W  = 22;
	localparam int PEN_W = retf_pkg::PENALTY_W + SQ_W;

	logic [2:0]                        state_q;
	retf_pkg::evt_t                    ev_q;
	logic [1:0]                        seen_q;
	logic [retf_pkg::POS_W-1:0]        rpos_q [2];
	logic [retf_pkg::STRENGTH_W-1:0]   rstr_q [2];
	logic [retf_pkg::SCORE_W-1:0]      top_q;
	logic [retf_pkg::POS_W-1:0]        tpos_q [3];
	logic [SQ_W-1:0]                   sq_q;
	logic [retf_pkg::SCORE_W-1:0]      sum_q;
	logic [PEN_W-1:0]                  pen_q;
	logic                              out_valid_q;
	retf_pkg::res_t                    out_q;

	logic signed [11:0]                gap_diff;
	logic signed [23:0]                gap_sq;
	logic [PEN_W:0]                    bar;
	logic                              better;
	logic                              load_out;

	always_comb begin
		// Difference of the two gaps: pos - 2*p1 + p0.
		gap_diff = $signed({2'b00, ev_q.pos}) - $signed({1'b0, rpos_q[1], 1'b0})
			+ $signed({2'b00, rpos_q[0]});
		gap_sq   = gap_diff * gap_diff;
		// The score beats the kept best when sum > penalty term + best.
		bar      = {1'b0, pen_q} + (PEN_W + 1)'(top_q);
		better   = (PEN_W + 1)'(sum_q) > bar;
	end

	assign pop       = (state_q == S_IDLE) && !empty;
	assign load_out  = (state_q == S_FIN) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_q <= head;
		end
		if (state_q == S_SQ) begin
			sq_q  <= gap_sq[SQ_W-1:0];
			sum_q <= retf_pkg::SCORE_W'(rstr_q[0]) + retf_pkg::SCORE_W'(rstr_q[1])
				+ retf_pkg::SCORE_W'(ev_q.strength);
		end
		if (state_q == S_PEN) begin
			pen_q <= gap_penalty * sq_q;
		end
		if (load_out) begin
			out_q.found <= top_q != '0;
			out_q.pos0  <= (top_q != '0) ? tpos_q[0] : '0;
			out_q.pos1  <= (top_q != '0) ? tpos_q[1] : '0;
			out_q.pos2  <= (top_q != '0) ? tpos_q[2] : '0;
			out_q.score <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seen_q      <= '0;
			rpos_q[0]   <= '0;
			rpos_q[1]   <= '0;
			rstr_q[0]   <= '0;
			rstr_q[1]   <= '0;
			top_q       <= '0;
			tpos_q[0]   <= '0;
			tpos_q[1]   <= '0;
			tpos_q[2]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= head.edge_hit ? S_SQ : S_FIN;
					end
				end
				S_SQ: begin
					state_q <= S_PEN;
				end
				S_PEN: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (seen_q == 2'd2 && better) begin
						top_q     <= sum_q - pen_q[retf_pkg::SCORE_W-1:0];
						tpos_q[0] <= rpos_q[0];
						tpos_q[1] <= rpos_q[1];
						tpos_q[2] <= ev_q.pos;
					end
					rpos_q[0] <= rpos_q[1];
					rstr_q[0] <= rstr_q[1];
					rpos_q[1] <= ev_q.pos;
					rstr_q[1] <= ev_q.strength;
					if (seen_q != 2'd2) begin
						seen_q <= seen_q + 1'b1;
					end
					state_q <= ev_q.last ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					if (load_out) begin
						seen_q    <= '0;
						rpos_q[0] <= '0;
						rpos_q[1] <= '0;
						rstr_q[0] <= '0;
						rstr_q[1] <= '0;
						top_q     <= '0;
						tpos_q[0] <= '0;
						tpos_q[1] <= '0;
						tpos_q[2] <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/ray_edge_triple_finder.sv]
// Ray edge triple finder: pixels of one ray stream in, one per cycle while the
// event queue has room, and the best triple of edge transitions comes out at the
// end of the ray. The front end updates the running mean with one multiply per
// pixel and takes a pixel every cycle while the queue has room; only transitions
// and end-of-ray pixels enter the event queue (EVQ_DEPTH entries). The back end
// takes a transition through pop, gap square, penalty multiply and compare, and
// an end-of-ray event through pop and final, or from compare to final when it
// closes a transition on the same pixel; it holds in its final state while the
// previous result waits on m_axis_tready. Input therefore stalls only when the
// queue fills: transitions outpacing the back end for longer than the queue can
// absorb, or a result held back at the output. No clearing pass after reset.
// Depends on retf_pkg, retf_front, retf_evq and retf_back.
module ray_edge_triple_finder #(
	parameter int MAX_RAY_LENGTH = retf_pkg::MAX_RAY_LENGTH_DEFAULT,
	parameter int EVQ_DEPTH      = retf_pkg::EVQ_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // pixel_value[7:0]
	input  logic                              s_axis_tlast,  // end_of_ray
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// first_position[9:0], second_position[19:10], third_position[29:20],
	// best_score[47:30]
	output logic [47:0]                       m_axis_tdata,
	output logic [0:0]                        m_axis_tuser,  // found[0]
	input  logic                              cfg_we,
	input  logic [retf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [retf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	retf_pkg::cfg_t cfg_q;
	retf_pkg::evt_t evt_in;
	retf_pkg::evt_t evt_head;
	retf_pkg::res_t res;
	logic           evt_push;
	logic           evt_pop;
	logic           evq_full;
	logic           evq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mean_rate      <= retf_pkg::MEAN_RATE_RESET;
			cfg_q.edge_threshold <= retf_pkg::EDGE_THRESHOLD_RESET;
			cfg_q.gap_penalty    <= retf_pkg::GAP_PENALTY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				retf_pkg::REG_MEAN_RATE: begin
					cfg_q.mean_rate <= cfg_wdata[retf_pkg::RATE_W-1:0];
				end
				retf_pkg::REG_EDGE_THRESHOLD: begin
					cfg_q.edge_threshold <= cfg_wdata[retf_pkg::THRESH_W-1:0];
				end
				retf_pkg::REG_GAP_PENALTY: begin
					cfg_q.gap_penalty <= cfg_wdata[retf_pkg::PENALTY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	retf_front #(
		.MAX_RAY_LENGTH(MAX_RAY_LENGTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pix_valid(s_axis_tvalid),
		.pix      (s_axis_tdata),
		.pix_last (s_axis_tlast),
		.evq_full (evq_full),
		.pix_ready(s_axis_tready),
		.evt_push (evt_push),
		.evt      (evt_in)
	);

	retf_evq #(
		.DEPTH(EVQ_DEPTH)
	) u_evq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (evt_push),
		.push_data(evt_in),
		.pop      (evt_pop),
		.head     (evt_head),
		.full     (evq_full),
		.empty    (evq_empty)
	);

	retf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gap_penalty(cfg_q.gap_penalty),
		.head       (evt_head),
		.empty      (evq_empty),
		.pop        (evt_pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = {res.score, res.pos2, res.pos1, res.pos0};
	assign m_axis_tuser = res.found;

	// A result without a triple carries all-zero positions and score.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("result without triple has nonzero payload");

	// A found triple has a positive score and positions in ray order.
	a_found_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			res.score != '0 && res.pos0 <= res.pos1 && res.pos1 <= res.pos2)
		else $error("found triple out of order or with zero score");

	// The queue never takes an event while it is full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		evq_full && !evt_pop |-> !evt_push)
		else $error("event queue overflow");

endmodule
